[rtl/core/sim_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the structural intron marker
// no dependencies; every other file of the block imports this package
package sim_pkg;

   // fixed field widths of the instruction and result transactions
   localparam int unsigned RegIdxWidth   = 3;
   localparam int unsigned NumRegsWidth  = 4;
   localparam int unsigned LiveSetWidth  = 8;
   // wide enough to compare any register index against any mask position
   localparam int unsigned IdxCmpWidth   = 7;

   // register file of the evaluated machine
   localparam int unsigned RegsDefault   = 8;
   localparam int unsigned RegsMax       = 64;

   // configuration port
   localparam int unsigned CsrAddrWidth  = 3;
   localparam int unsigned CsrDataWidth  = 32;
   localparam int unsigned CsrIdxWidth   = CsrAddrWidth - 2;
   localparam logic [CsrIdxWidth-1:0] RegIdxNumRegisters = 1'b0;
   localparam logic [NumRegsWidth-1:0] NumRegsReset = 4'd8;

   // one instruction as it travels through the block
   typedef struct packed {
      logic                   scan_start;
      logic [RegIdxWidth-1:0] dest_reg;
      logic [RegIdxWidth-1:0] src_one_reg;
      logic                   src_one_is_const;
      logic [RegIdxWidth-1:0] src_two_reg;
      logic                   src_two_is_const;
      logic                   is_branch;
   } sim_instr_type;

   // input register contents handed to the marker stage
   typedef struct packed {
      logic          valid;
      sim_instr_type instr;
   } sim_stage_type;

endpackage

[rtl/core/sim_channels_if.sv]
`timescale 1ns / 1ps
// valid/ready channel interfaces for instruction and result transactions
// depends on sim_pkg for field widths
interface sim_req_if;
   import sim_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   scan_start;
   logic [RegIdxWidth-1:0] dest_reg;
   logic [RegIdxWidth-1:0] src_one_reg;
   logic                   src_one_is_const;
   logic [RegIdxWidth-1:0] src_two_reg;
   logic                   src_two_is_const;
   logic                   is_branch;

   modport source (
      output valid, scan_start, dest_reg, src_one_reg, src_one_is_const,
             src_two_reg, src_two_is_const, is_branch,
      input  ready
   );

   modport sink (
      input  valid, scan_start, dest_reg, src_one_reg, src_one_is_const,
             src_two_reg, src_two_is_const, is_branch,
      output ready
   );
endinterface

interface sim_rsp_if;
   import sim_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    is_effective;
   logic [LiveSetWidth-1:0] live_set;

   modport source (
      output valid, is_effective, live_set,
      input  ready
   );

   modport sink (
      input  valid, is_effective, live_set,
      output ready
   );
endinterface

[rtl/core/sim_csr.sv]
`timescale 1ns / 1ps
// apb-style configuration register file: holds num_registers
// depends on sim_pkg
module sim_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sim_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [sim_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [sim_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready,
   output logic [sim_pkg::NumRegsWidth-1:0]    num_registers
);
   import sim_pkg::*;

   logic [NumRegsWidth-1:0] num_regs_ff;
   logic [NumRegsWidth-1:0] num_regs_in;
   logic [CsrIdxWidth-1:0]  reg_idx;
   logic                    wr_hit;

   assign reg_idx    = csr_paddr[CsrAddrWidth-1:2];
   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (reg_idx == RegIdxNumRegisters);

   always_comb begin
      num_regs_in = num_regs_ff;
      if (wr_hit) begin
         num_regs_in = csr_pwdata[NumRegsWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_regs_ff <= NumRegsReset;
      end else begin
         num_regs_ff <= num_regs_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == RegIdxNumRegisters) begin
         csr_prdata[NumRegsWidth-1:0] = num_regs_ff;
      end
   end

   assign num_registers = num_regs_ff;

endmodule

[rtl/core/sim_input_stage.sv]
`timescale 1ns / 1ps
// input register for instruction transactions
// depends on sim_pkg and sim_req_if
module sim_input_stage (
   input  logic                   clock,
   input  logic                   reset,
   sim_req_if.sink                req,
   input  logic                   stage_ready,
   output sim_pkg::sim_stage_type stage
);
   import sim_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   sim_instr_type instr_ff;
   logic          req_fire;

   // space when empty or when the marker takes the held item this cycle
   assign req.ready = !valid_ff || stage_ready;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (stage_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         instr_ff.scan_start       <= req.scan_start;
         instr_ff.dest_reg         <= req.dest_reg;
         instr_ff.src_one_reg      <= req.src_one_reg;
         instr_ff.src_one_is_const <= req.src_one_is_const;
         instr_ff.src_two_reg      <= req.src_two_reg;
         instr_ff.src_two_is_const <= req.src_two_is_const;
         instr_ff.is_branch        <= req.is_branch;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.instr = instr_ff;

endmodule

[rtl/core/sim_marker.sv]
`timescale 1ns / 1ps
// liveness state, per-instruction effectiveness decision and result register
// depends on sim_pkg and sim_rsp_if
module sim_marker #(
   parameter int unsigned REGS = sim_pkg::RegsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  sim_pkg::sim_stage_type           stage,
   output logic                             stage_ready,
   input  logic [sim_pkg::NumRegsWidth-1:0] num_registers,
   sim_rsp_if.source                        rsp
);
   import sim_pkg::*;

   logic [REGS-1:0] live_mask_ff;
   logic [REGS-1:0] live_mask_in;
   logic            later_eff_ff;
   logic            later_eff_in;
   logic            have_later_ff;
   logic            have_later_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    rsp_eff_ff;
   logic [LiveSetWidth-1:0] rsp_live_ff;

   logic            fire;
   logic [REGS-1:0] start_mask;
   logic [REGS-1:0] dest_bit;
   logic [REGS-1:0] src_one_bit;
   logic [REGS-1:0] src_two_bit;
   logic [REGS-1:0] base_mask;
   logic [REGS-1:0] killed_mask;
   logic            base_have_later;
   logic            eff;
   logic [LiveSetWidth-1:0] live_low;

   assign stage_ready = !rsp_valid_ff || rsp.ready;
   assign fire        = stage.valid && stage_ready;

   // one-hot register selects; indices at or above REGS select nothing
   for (genvar i = 0; i < REGS; i++) begin : g_bits
      assign start_mask[i]  = IdxCmpWidth'(num_registers) > IdxCmpWidth'(i);
      assign dest_bit[i]    = IdxCmpWidth'(stage.instr.dest_reg) == IdxCmpWidth'(i);
      assign src_one_bit[i] = IdxCmpWidth'(stage.instr.src_one_reg) == IdxCmpWidth'(i);
      assign src_two_bit[i] = IdxCmpWidth'(stage.instr.src_two_reg) == IdxCmpWidth'(i);
   end

   always_comb begin
      base_mask       = stage.instr.scan_start ? start_mask : live_mask_ff;
      base_have_later = stage.instr.scan_start ? 1'b0 : have_later_ff;
      killed_mask     = base_mask;

      if (stage.instr.is_branch && base_have_later) begin
         // conditional follows the instruction after it
         eff = later_eff_ff;
      end else begin
         eff = |(base_mask & dest_bit);
         if (eff && !stage.instr.is_branch) begin
            killed_mask = base_mask & ~dest_bit;
         end
      end

      live_mask_in = killed_mask;
      if (eff) begin
         if (!stage.instr.src_one_is_const) begin
            live_mask_in = live_mask_in | src_one_bit;
         end
         if (!stage.instr.src_two_is_const) begin
            live_mask_in = live_mask_in | src_two_bit;
         end
      end

      later_eff_in  = eff;
      have_later_in = 1'b1;
   end

   // low byte of the new mask, zero above REGS
   for (genvar j = 0; j < LiveSetWidth; j++) begin : g_low
      if (j < REGS) begin : g_in
         assign live_low[j] = live_mask_in[j];
      end else begin : g_out
         assign live_low[j] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_mask_ff  <= '1;
         later_eff_ff  <= 1'b0;
         have_later_ff <= 1'b0;
      end else if (fire) begin
         live_mask_ff  <= live_mask_in;
         later_eff_ff  <= later_eff_in;
         have_later_ff <= have_later_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_eff_ff  <= eff;
         rsp_live_ff <= live_low;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.is_effective = rsp_eff_ff;
   assign rsp.live_set     = rsp_live_ff;

   // scan state moves only when an instruction is taken
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(live_mask_ff) && $stable(have_later_ff) && $stable(later_eff_ff))
      else $error("scan state changed without a transaction");

   // after any instruction a later one of the scan exists
   a_have_later: assert property (@(posedge clock) disable iff (reset)
      fire |=> have_later_ff)
      else $error("have_later not set after a transaction");

   // reported effectiveness is what the next conditional will follow
   a_eff_tracks: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff && (rsp_eff_ff == later_eff_ff))
      else $error("result and later_effective disagree");

   // an intron in the middle of a scan leaves the mask alone
   a_intron_keeps_mask: assert property (@(posedge clock) disable iff (reset)
      fire && !eff && !stage.instr.scan_start |=> $stable(live_mask_ff))
      else $error("intron changed the live mask");

endmodule

[rtl/core/structural_intron_marker_core.sv]
`timescale 1ns / 1ps
// top level of the structural intron marker
// depends on sim_pkg, sim_channels_if, sim_csr, sim_input_stage, sim_marker
//
// usage
// - req_chan carries one program instruction per transaction, last instruction
//   first; scan_start = 1 on the last instruction reloads the live mask with
//   the low num_registers bits (saturated at REGS) and forgets the later one
// - rsp_chan returns one transaction per instruction, in order: is_effective
//   and live_set, the low byte of the live mask after that instruction
// - the csr port holds num_registers at byte address 0; writes complete in
//   the access cycle, pready is tied high, reads return the stored value
// - path: an accepted instruction fills the input register, and its result
//   is then written into the result register
// - throughput: one instruction per cycle while rsp_chan does not stall; the
//   scan state loops (live mask, later effect, have_later) are and/or terms
// - when rsp_chan stalls, the held result waits in the result register and
//   one more instruction is taken into the input register; after that
//   req_chan.ready drops until the result is taken
// - reset (synchronous, active high) marks all REGS registers live, clears
//   the scan history, empties both registers and sets num_registers to 8
module structural_intron_marker_core #(
   parameter int unsigned REGS = sim_pkg::RegsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   sim_req_if.sink                          req_chan,
   sim_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sim_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [sim_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [sim_pkg::CsrDataWidth-1:0] csr_prdata,
   output logic                             csr_pready
);
   import sim_pkg::*;

   // configuration: user keeps it stable while instructions flow; unenforced
   logic [NumRegsWidth-1:0] num_registers;
   // input register contents and the marker's ready back to it
   sim_stage_type           stage;
   logic                    stage_ready;

   sim_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .num_registers (num_registers)
   );

   // instruction transactions land here first
   sim_input_stage u_input_stage (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .stage_ready (stage_ready),
      .stage       (stage)
   );

   // liveness decision and result register
   sim_marker #(
      .REGS (REGS)
   ) u_marker (
      .clock         (clock),
      .reset         (reset),
      .stage         (stage),
      .stage_ready   (stage_ready),
      .num_registers (num_registers),
      .rsp           (rsp_chan)
   );

endmodule
